// ----- rtl/core/fbfl_pkg.sv -----
// Shared types, constants and helpers of the fixed-block free-list allocator.
`default_nettype none

package fbfl_pkg;

    localparam int NUM_BLOCKS = 256;
    localparam int IDX_W      = $clog2(NUM_BLOCKS);
    localparam int LINK_W     = IDX_W + 1;
    localparam int POOL_W     = 9;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [LINK_W-1:0] link_t;
    typedef logic [POOL_W-1:0] pool_t;

    // Link value that ends the chain
    localparam link_t NULL_LINK = LINK_W'(NUM_BLOCKS);
    localparam pool_t POOL_MAX  = POOL_W'(NUM_BLOCKS);
    localparam pool_t POOL_RST  = POOL_W'(256);

    typedef enum logic [1:0] {
        KIND_ALLOC       = 2'd0,
        KIND_RELEASE     = 2'd1,
        KIND_RELEASE_ALL = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_RANGE = 2'd2
    } stat_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } dp_cmd_t;

    // Pool size after a rebuild: zero counts as one, clamp at the pool depth
    function automatic pool_t clamp_pool(input pool_t req);
        pool_t res;
        res = req;
        if (req == '0)
        begin
            res = POOL_W'(1);
        end
        else if (req > POOL_MAX)
        begin
            res = POOL_MAX;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/fbfl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fbfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/fbfl_ctrl.sv -----
// Control state machine: input/output handshakes and datapath sequencing.
`default_nettype none

module fbfl_ctrl
    import fbfl_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    output dp_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        s_tready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                // take a new beat once the result slot is free or draining
                s_tready    = !m_valid_reg || m_tready;
                cmd.capture = s_tvalid && s_tready;
                if (cmd.capture)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.execute  = 1'b1;
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;

endmodule

`default_nettype wire

// ----- rtl/core/fbfl_dp.sv -----
// Datapath: head, link memory with lazy-init valid bits, pool size, result registers.
`default_nettype none

module fbfl_dp
    import fbfl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dp_cmd_t           cmd,
    input  wire logic              cfg_we,
    input  wire logic [POOL_W-1:0] cfg_wdata,
    input  wire logic [1:0]        in_kind,
    input  wire logic [IDX_W-1:0]  in_index,
    output logic      [IDX_W-1:0]  out_grant,
    output logic      [1:0]        out_status
);

    pool_t                 pool_size_reg;
    pool_t                 active_reg;
    pool_t                 active_next;
    link_t                 head_reg;
    link_t                 head_next;
    logic [NUM_BLOCKS-1:0] valid_reg;
    logic [NUM_BLOCKS-1:0] valid_next;
    kind_t                 kind_reg;
    idx_t                  idx_reg;
    idx_t                  grant_reg;
    idx_t                  grant_next;
    stat_t                 status_reg;
    stat_t                 status_next;

    logic  ram_we;
    link_t ram_rdata;
    link_t dflt_link;
    link_t link_val;
    link_t head_inc;

    fbfl_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NUM_BLOCKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (head_reg),
        .raddr (head_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // Unwritten entries read as the rebuilt chain i -> i+1
    assign head_inc  = LINK_W'(head_reg[IDX_W-1:0]) + LINK_W'(1);
    assign dflt_link = (POOL_W'(head_inc) < active_reg) ? head_inc : NULL_LINK;
    assign link_val  = valid_reg[head_reg[IDX_W-1:0]] ? ram_rdata : dflt_link;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_size_reg <= POOL_RST;
            active_reg    <= clamp_pool(POOL_RST);
            head_reg      <= '0;
            valid_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                pool_size_reg <= cfg_wdata;
            end
            active_reg <= active_next;
            head_reg   <= head_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind_t'(in_kind);
            idx_reg  <= in_index;
        end
        if (cmd.execute)
        begin
            grant_reg  <= grant_next;
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        active_next = active_reg;
        head_next   = head_reg;
        valid_next  = valid_reg;
        grant_next  = '0;
        status_next = STAT_OK;
        ram_we      = 1'b0;
        if (cmd.execute)
        begin
            case (kind_reg)
                KIND_ALLOC:
                begin
                    if (POOL_W'(head_reg) >= active_reg)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        grant_next = head_reg[IDX_W-1:0];
                        head_next  = link_val;
                    end
                end
                KIND_RELEASE:
                begin
                    if (POOL_W'(idx_reg) >= active_reg)
                    begin
                        status_next = STAT_RANGE;
                    end
                    else
                    begin
                        ram_we              = 1'b1;
                        valid_next[idx_reg] = 1'b1;
                        head_next           = LINK_W'(idx_reg);
                    end
                end
                KIND_RELEASE_ALL:
                begin
                    active_next = clamp_pool(pool_size_reg);
                    valid_next  = '0;
                    head_next   = '0;
                end
                default:
                begin
                    status_next = STAT_OK;
                end
            endcase
        end
    end

    assign out_grant  = grant_reg;
    assign out_status = status_reg;

endmodule

`default_nettype wire

// ----- rtl/core/fixed_block_free_list_allocator.sv -----
// Top level of the fixed-block pool allocator with a LIFO free list.
//
//  Channel  | Direction | Payload
//  ---------+-----------+-----------------------------------------------
//  s_axis   | in        | tuser = kind, tdata = block_index
//  m_axis   | out       | tuser = status, tdata = granted_index
//  cfg      | in        | cfg_wdata = pool_size, written when cfg_we is high
//
// Each beat is captured, with the head's link read from the link RAM
// (registered read), then executed: the head is updated and the result loaded.
// The result register frees the input side: a new beat is taken while the
// previous result is being accepted. Reset and release-all take effect at
// once; per-block valid bits stand in for the rebuilt chain, so no clearing
// pass runs. A stalled output holds its beat and blocks new input beats.
`default_nettype none

module fixed_block_free_list_allocator
    import fbfl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration: pool_size
    input  wire logic              cfg_we,
    input  wire logic [POOL_W-1:0] cfg_wdata,
    // input beats
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // [7:0] block_index
    input  wire logic [1:0]        s_tuser,   // [1:0] kind
    // result beats
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [7:0]        m_tdata,   // [7:0] granted_index
    output logic      [1:0]        m_tuser    // [1:0] status
);

    dp_cmd_t cmd;

    // sequence capture and execute, own both handshakes
    fbfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // free list state and result registers
    fbfl_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_kind    (s_tuser),
        .in_index   (s_tdata[IDX_W-1:0]),
        .out_grant  (m_tdata[IDX_W-1:0]),
        .out_status (m_tuser)
    );

endmodule

`default_nettype wire

// ----- dv/fixed_block_free_list_allocator_tb.sv -----
// Self-checking testbench for the fixed-block free-list allocator: streamed requests, tracked pool.
module fixed_block_free_list_allocator_tb;
    import fbfl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Kind code that the block treats as a no-op
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    // Cycles without any accepted beat before the run is declared hung
    localparam int STALL_LIMIT = 1000;
    // Requests per random phase, after its opening release-all
    localparam int PHASE_REQS = 42;

    typedef struct packed {
        logic [1:0] kind;
        idx_t       block;
    } pool_req_t;

    typedef struct packed {
        idx_t  granted;
        stat_t status;
    } grant_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [POOL_W-1:0] cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = '0;   // [7:0] block_index
    logic [1:0]        s_tuser   = '0;   // [1:0] kind
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [7:0]        m_tdata;          // [7:0] granted_index
    logic [1:0]        m_tuser;          // [1:0] status

    // Stimulus waiting for the driver, and grants predicted for accepted requests
    pool_req_t pending_requests[$];
    grant_t    predicted_grants[$];

    // Tracked copy of the free list
    pool_t pool_req;              // last value written to pool_size
    pool_t live_blocks;           // blocks in the pool since the last rebuild
    link_t free_head_q;
    link_t link_tbl [NUM_BLOCKS];

    int  fail_count  = 0;
    int  send_wait   = 0;
    int  recv_wait   = 0;
    int  idle_cycles = 0;
    bit  send_steady = 1'b0;
    bit  recv_steady = 1'b0;

    fixed_block_free_list_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Rebuild the chain 0..n-1 from the latched pool size; zero counts as one,
    // anything above the pool depth clamps to it.
    function automatic void rebuild_pool();
        pool_t n;
        n = pool_req;
        if (n == '0)
            n = POOL_W'(1);
        else if (n > POOL_W'(NUM_BLOCKS))
            n = POOL_W'(NUM_BLOCKS);
        live_blocks = n;
        for (int i = 0; i < NUM_BLOCKS; i++)
            link_tbl[i] = (i + 1 < n) ? LINK_W'(i + 1) : NULL_LINK;
        free_head_q = '0;
    endfunction

    // Apply one accepted request to the tracked list and queue the grant it yields.
    function automatic void pool_track_op(input logic [1:0] kind, input idx_t block);
        grant_t res;
        res.granted = '0;
        res.status  = STAT_OK;
        case (kind)
            KIND_ALLOC:
            begin
                // Null head (or a head past the live range) means the pool is drained
                if (free_head_q >= live_blocks)
                    res.status = STAT_EMPTY;
                else
                begin
                    res.granted = free_head_q[IDX_W-1:0];
                    free_head_q = link_tbl[free_head_q[IDX_W-1:0]];
                end
            end
            KIND_RELEASE:
            begin
                // Out-of-range release is flagged and dropped; a double release
                // is pushed without any check
                if (LINK_W'(block) >= live_blocks)
                    res.status = STAT_RANGE;
                else
                begin
                    link_tbl[block] = free_head_q;
                    free_head_q     = LINK_W'(block);
                end
            end
            KIND_RELEASE_ALL:
                rebuild_pool();
            default:
                ;
        endcase
        predicted_grants.push_back(res);
    endfunction

    // Request driver: predict on every accepted beat, then present the next
    // request once its random gap has run out.
    always @(posedge clk or negedge rst_n)
    begin : req_driver
        pool_req_t nxt;
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            s_tuser   <= '0;
            send_wait <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                pool_track_op(s_tuser, s_tdata);
            // Hold the beat while the block stalls it
            if (!s_tvalid || s_tready)
            begin
                if (send_wait != 0)
                begin
                    send_wait <= send_wait - 1;
                    s_tvalid  <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    nxt = pending_requests.pop_front();
                    s_tvalid  <= 1'b1;
                    s_tuser   <= nxt.kind;
                    s_tdata   <= nxt.block;
                    send_wait <= send_steady ? 0 : $urandom_range(0, 14);
                    // Flip now and then between gapped traffic and back-to-back beats
                    if ($urandom_range(0, 39) == 0)
                        send_steady <= !send_steady;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Grant monitor: check each accepted result beat against the oldest
    // prediction, then hold back the next one by a random stall, which may be none.
    always @(posedge clk or negedge rst_n)
    begin : grant_monitor
        grant_t want;
        int     stall;
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            recv_wait <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            if (predicted_grants.size() == 0)
            begin
                $error("unexpected result beat: granted_index %0d, status %0d",
                       m_tdata, m_tuser);
                fail_count++;
            end
            else
            begin
                want = predicted_grants.pop_front();
                if (m_tdata !== want.granted)
                begin
                    $error("granted_index mismatch: expected %0d, actual %0d",
                           want.granted, m_tdata);
                    fail_count++;
                end
                if (m_tuser !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, m_tuser);
                    fail_count++;
                end
            end
            stall = recv_steady ? 0 : $urandom_range(0, 14);
            recv_wait <= stall;
            m_tready  <= (stall == 0);
            if ($urandom_range(0, 39) == 0)
                recv_steady <= !recv_steady;
        end
        else if (recv_wait != 0)
        begin
            recv_wait <= recv_wait - 1;
            m_tready  <= (recv_wait == 1);
        end
        else
            m_tready <= 1'b1;
    end

    // Watchdog: drop the run if no beat moves on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic queue_req(input logic [1:0] kind, input idx_t block);
        pool_req_t r;
        r.kind  = kind;
        r.block = block;
        pending_requests.push_back(r);
    endtask

    // Block until every queued request is sent and every grant has come back
    task automatic wait_drained();
        while (pending_requests.size() != 0 || s_tvalid || predicted_grants.size() != 0)
            @(negedge clk);
    endtask

    // Write pool_size while the block is idle; it applies at the next release-all
    task automatic set_pool_size(input pool_t size_req);
        wait_drained();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= size_req;
        @(posedge clk);
        cfg_we   <= 1'b0;
        pool_req = size_req;
        @(negedge clk);
    endtask

    // One random phase: rebuild at the new size, then a mix of allocates, releases
    // aimed mostly at live blocks, some noise, and occasional release-alls and no-op kinds.
    task automatic random_phase(input pool_t size_req);
        int eff;
        int alloc_pct;
        int pick;
        eff = (size_req == 0) ? 1 : (size_req > NUM_BLOCKS) ? NUM_BLOCKS : int'(size_req);
        alloc_pct = $urandom_range(30, 60);
        set_pool_size(size_req);
        queue_req(KIND_RELEASE_ALL, idx_t'($urandom_range(0, 255)));
        for (int k = 0; k < PHASE_REQS; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < alloc_pct)
                queue_req(KIND_ALLOC, idx_t'($urandom_range(0, 255)));
            else if (pick < 90)
                // Live blocks, plus the first index past the end
                queue_req(KIND_RELEASE, idx_t'($urandom_range(0, eff)));
            else if (pick < 95)
                queue_req(KIND_RELEASE, idx_t'($urandom_range(0, 255)));
            else if (pick < 98)
                queue_req(KIND_RELEASE_ALL, idx_t'($urandom_range(0, 255)));
            else
                queue_req(KIND_UNUSED, idx_t'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        pool_req = POOL_RST;
        rebuild_pool();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Full pool out of reset: pops in order, top index, double release, no-op kind
        queue_req(KIND_ALLOC, 8'h00);
        queue_req(KIND_ALLOC, 8'hFF);
        queue_req(KIND_ALLOC, 8'h00);
        queue_req(KIND_RELEASE, 8'hFF);
        queue_req(KIND_ALLOC, 8'h00);
        queue_req(KIND_RELEASE, 8'h00);
        queue_req(KIND_RELEASE, 8'h00);
        queue_req(KIND_ALLOC, 8'h00);
        queue_req(KIND_ALLOC, 8'h00);
        queue_req(KIND_ALLOC, 8'h00);
        queue_req(KIND_UNUSED, 8'hAA);
        queue_req(KIND_RELEASE_ALL, 8'h55);
        queue_req(KIND_ALLOC, 8'h00);

        // Size zero acts as one block: drain it, release out of range, refill
        set_pool_size(POOL_W'(0));
        queue_req(KIND_RELEASE_ALL, 8'h00);
        queue_req(KIND_ALLOC, 8'h00);
        queue_req(KIND_ALLOC, 8'h00);
        queue_req(KIND_RELEASE, 8'h01);
        queue_req(KIND_RELEASE, 8'h00);
        queue_req(KIND_ALLOC, 8'h00);

        // Largest register value clamps to the pool depth
        set_pool_size(POOL_W'(511));
        queue_req(KIND_RELEASE_ALL, 8'h00);
        queue_req(KIND_RELEASE, 8'hFF);
        queue_req(KIND_ALLOC, 8'h00);

        set_pool_size(POOL_MAX);
        queue_req(KIND_RELEASE_ALL, 8'h00);
        queue_req(KIND_ALLOC, 8'h00);

        // Mostly small pools so that empty and out-of-range cases come often
        random_phase(POOL_W'(1));
        random_phase(POOL_W'(2));
        random_phase(POOL_W'(3));
        random_phase(POOL_W'(5));
        random_phase(POOL_W'(8));
        random_phase(POOL_W'($urandom_range(4, 16)));
        random_phase(POOL_W'($urandom_range(1, 511)));
        random_phase(POOL_MAX);
        random_phase(POOL_W'(16));
        random_phase(POOL_W'(0));

        wait_drained();
        // Let any stray result beat surface before the verdict
        repeat (8) @(posedge clk);
        if (predicted_grants.size() != 0)
        begin
            $error("%0d predicted grants never arrived", predicted_grants.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/fbfl_pkg.sv
rtl/core/fbfl_ram.sv
rtl/core/fbfl_ctrl.sv
rtl/core/fbfl_dp.sv
rtl/core/fixed_block_free_list_allocator.sv
dv/fixed_block_free_list_allocator_tb.sv
